>>> design/amgs_pkg.sv
package amgs_pkg;

  localparam int MaxVertices = 64;
  localparam int IdxBits     = 6;
  localparam int CntBits     = 7;
  localparam int WeightBits  = 32;
  localparam int CountBits   = 13;

  localparam logic [3:0] FN_CONNECT    = 4'd0;
  localparam logic [3:0] FN_DISCONNECT = 4'd1;
  localparam logic [3:0] FN_QUERY      = 4'd2;
  localparam logic [3:0] FN_SET_WEIGHT = 4'd3;
  localparam logic [3:0] FN_NEXT_EDGE  = 4'd4;
  localparam logic [3:0] FN_NEXT_IN    = 4'd5;
  localparam logic [3:0] FN_NEXT_OUT   = 4'd6;
  localparam logic [3:0] FN_IN_DEGREE  = 4'd7;
  localparam logic [3:0] FN_OUT_DEGREE = 4'd8;
  localparam logic [3:0] FN_COUNT_ALL  = 4'd9;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOVERT = 2'd1;
  localparam logic [1:0] ST_NOEDGE = 2'd2;
  localparam logic [1:0] ST_END    = 2'd3;

  localparam logic [0:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [0:0] CFG_DIRECTED     = 1'b1;

  localparam logic [WeightBits-1:0] W_ONE = 32'h0001_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RD_A, S_WR_A, S_RD_B, S_WR_B, S_SCAN, S_WRD, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    RK_ZERO, RK_NOVERT, RK_CONN, RK_DISC, RK_QRY, RK_END, RK_COUNT, RK_FOUND
  } res_kind_t;

  typedef struct packed {
    logic      accept;
    logic      init;
    logic      rd_a;
    logic      wr_a;
    logic      rd_b;
    logic      wr_b;
    logic      scan;
    logic      rd_found;
    logic      load;
    res_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       bad;
    logic       mirror;
    logic       present;
    logic       hit;
    logic       scan_done;
    logic       out_free;
  } sts_t;

endpackage

>>> design/adjacency_matrix_graph_store.sv
// Channel    Handshake               Payload
// request    req_valid / req_stall   func, src, dst, inclusive, weight
// response   rsp_valid / rsp_stall   status, found_src, found_dst, edge_present,
//                                    weight_out, count_value
// config     cfg_en                  cfg_index, cfg_data
//
// Edge operations decode, read and write the source row, and load the result; when a write is
// mirrored into the opposite row they also read and write that row. Scans and counts read one
// 64-bit matrix row per cycle from the row memory, in order: accept, decode, the row reads, a
// check of the last row, then the end check or, on a hit, the weight read, and the result load.
// One transaction is in flight at a time; a new request is taken while a result waits.
// Reset is synchronous; it clears per-row valid flags so the matrix reads as empty at once.
// A stalled response holds the block in its result state until the response is taken.
module adjacency_matrix_graph_store import amgs_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_en,
  input  logic [0:0]                   cfg_index,
  input  logic [CntBits-1:0]           cfg_data,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [3:0]                   func,
  input  logic [IdxBits-1:0]           src,
  input  logic [IdxBits-1:0]           dst,
  input  logic                         inclusive,
  input  logic signed [WeightBits-1:0] weight,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [1:0]                   status,
  output logic [IdxBits-1:0]           found_src,
  output logic [IdxBits-1:0]           found_dst,
  output logic                         edge_present,
  output logic signed [WeightBits-1:0] weight_out,
  output logic [CountBits-1:0]         count_value
);

  cmd_t cmd;
  sts_t sts;

  amgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  amgs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_en       (cfg_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .src          (src),
    .dst          (dst),
    .inclusive    (inclusive),
    .weight       (weight),
    .rsp_stall    (rsp_stall),
    .rsp_valid    (rsp_valid),
    .status       (status),
    .found_src    (found_src),
    .found_dst    (found_dst),
    .edge_present (edge_present),
    .weight_out   (weight_out),
    .count_value  (count_value),
    .cmd          (cmd),
    .sts          (sts)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while a transaction was in progress");

  a_novert_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_NOVERT |-> !edge_present && weight_out == 0 && count_value == 0)
    else $error("no-vertex response carries data");

  a_present_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && edge_present |-> status == ST_OK && count_value == 0)
    else $error("present edge reported with a failing status or a count");
`endif

endmodule

>>> design/amgs_ctrl.sv
module amgs_ctrl import amgs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t    state, state_next;
  res_kind_t kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= RK_ZERO;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    cmd.kind   = kind;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.init = 1'b1;
        if (sts.func > FN_COUNT_ALL) begin
          kind_next  = RK_ZERO;
          state_next = S_EMIT;
        end else if (sts.bad) begin
          kind_next  = RK_NOVERT;
          state_next = S_EMIT;
        end else if (sts.func <= FN_SET_WEIGHT) begin
          state_next = S_RD_A;
          if (sts.func == FN_CONNECT) kind_next = RK_CONN;
          else if (sts.func == FN_DISCONNECT) kind_next = RK_DISC;
          else kind_next = RK_QRY;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_RD_A: begin
        cmd.rd_a   = 1'b1;
        state_next = S_WR_A;
      end
      S_WR_A: begin
        cmd.wr_a = 1'b1;
        if (sts.mirror && (sts.func <= FN_DISCONNECT ||
            (sts.func == FN_SET_WEIGHT && sts.present))) begin
          state_next = S_RD_B;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_RD_B: begin
        cmd.rd_b   = 1'b1;
        state_next = S_WR_B;
      end
      S_WR_B: begin
        cmd.wr_b   = 1'b1;
        state_next = S_EMIT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          kind_next  = RK_FOUND;
          state_next = S_WRD;
        end else if (sts.scan_done) begin
          kind_next  = (sts.func >= FN_IN_DEGREE) ? RK_COUNT : RK_END;
          state_next = S_EMIT;
        end
      end
      S_WRD: begin
        cmd.rd_found = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> design/amgs_datapath.sv
module amgs_datapath import amgs_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_en,
  input  logic [0:0]                   cfg_index,
  input  logic [CntBits-1:0]           cfg_data,
  input  logic [3:0]                   func,
  input  logic [IdxBits-1:0]           src,
  input  logic [IdxBits-1:0]           dst,
  input  logic                         inclusive,
  input  logic signed [WeightBits-1:0] weight,
  input  logic                         rsp_stall,
  output logic                         rsp_valid,
  output logic [1:0]                   status,
  output logic [IdxBits-1:0]           found_src,
  output logic [IdxBits-1:0]           found_dst,
  output logic                         edge_present,
  output logic signed [WeightBits-1:0] weight_out,
  output logic [CountBits-1:0]         count_value,
  input  cmd_t                         cmd,
  output sts_t                         sts
);

  localparam int RowBits = MaxVertices;

  function automatic logic [CntBits-1:0] popcount(input logic [RowBits-1:0] v);
    logic [CntBits-1:0] acc;
    acc = '0;
    for (int i = 0; i < RowBits; i++) acc = acc + CntBits'(v[i]);
    return acc;
  endfunction

  logic [CntBits-1:0]    vcount;
  logic                  directed;
  logic [3:0]            f_q;
  logic [IdxBits-1:0]    s_q, d_q;
  logic                  incl_q;
  logic [WeightBits-1:0] w_q;

  logic [CntBits-1:0]    n;
  logic                  sok, dok;

  logic [2*RowBits-1:0]  row_mem [RowBits];
  logic [2*RowBits-1:0]  row_rdata;
  logic [IdxBits-1:0]    row_raddr, row_raddr_q;
  logic [RowBits-1:0]    row_valid;
  logic                  row_re, row_we;
  logic [IdxBits-1:0]    wr_row, wr_bit;
  logic [RowBits-1:0]    pres_eff, ever_eff, pres_new, ever_new;
  logic                  present_q, ever_q;

  logic [WeightBits-1:0] w_mem [RowBits*RowBits];
  logic [WeightBits-1:0] w_rdata;
  logic                  w_re, w_we;
  logic [2*IdxBits-1:0]  w_raddr, w_waddr;
  logic [WeightBits-1:0] w_wdata;

  logic [CntBits-1:0]    r, rend, c0;
  logic                  colmode, fst, chk_v, chk_first;
  logic [IdxBits-1:0]    chk_row, fr, fc, first_idx;
  logic [RowBits-1:0]    nmask, c0mask, mask, masked;
  logic [CountBits-1:0]  cnt;
  logic                  issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount   <= '0;
      directed <= 1'b0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT: vcount   <= cfg_data;
        CFG_DIRECTED:     directed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      f_q    <= func;
      s_q    <= src;
      d_q    <= dst;
      incl_q <= inclusive;
      w_q    <= weight;
    end
  end

  assign n   = (vcount > CntBits'(MaxVertices)) ? CntBits'(MaxVertices) : vcount;
  assign sok = {1'b0, s_q} < n;
  assign dok = {1'b0, d_q} < n;

  assign pres_eff = row_valid[row_raddr_q] ? row_rdata[RowBits-1:0] : '0;
  assign ever_eff = row_valid[row_raddr_q] ? row_rdata[2*RowBits-1:RowBits] : '0;

  assign issue  = cmd.scan && (r < rend);
  assign row_re = cmd.rd_a || cmd.rd_b || issue;
  always_comb begin
    if (cmd.rd_a) row_raddr = s_q;
    else if (cmd.rd_b) row_raddr = d_q;
    else row_raddr = r[IdxBits-1:0];
  end

  assign row_we = (cmd.wr_a && (f_q <= FN_DISCONNECT)) ||
                  (cmd.wr_b && (f_q <= FN_DISCONNECT || f_q == FN_SET_WEIGHT));
  assign wr_row = cmd.wr_a ? s_q : d_q;
  assign wr_bit = cmd.wr_a ? d_q : s_q;

  always_comb begin
    pres_new = pres_eff;
    ever_new = ever_eff;
    if (f_q <= FN_DISCONNECT) pres_new[wr_bit] = (f_q == FN_CONNECT);
    if (f_q != FN_DISCONNECT) ever_new[wr_bit] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (row_re) begin
      row_rdata   <= row_mem[row_raddr];
      row_raddr_q <= row_raddr;
    end
    if (row_we) row_mem[wr_row] <= {ever_new, pres_new};
  end

  always_ff @(posedge clk) begin
    if (rst) row_valid <= '0;
    else if (row_we) row_valid[wr_row] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      present_q <= pres_eff[d_q];
      ever_q    <= ever_eff[d_q];
    end
  end

  assign w_re    = cmd.rd_a || cmd.rd_found;
  assign w_raddr = cmd.rd_a ? {s_q, d_q} : {fr, fc};
  assign w_we    = (cmd.wr_a && (f_q == FN_CONNECT ||
                   (f_q == FN_SET_WEIGHT && pres_eff[d_q]))) ||
                   (cmd.wr_b && (f_q == FN_CONNECT || f_q == FN_SET_WEIGHT));
  assign w_waddr = cmd.wr_a ? {s_q, d_q} : {d_q, s_q};
  assign w_wdata = (f_q == FN_CONNECT) ? W_ONE : w_q;

  always_ff @(posedge clk) begin
    if (w_re) w_rdata <= w_mem[w_raddr];
    if (w_we) w_mem[w_waddr] <= w_wdata;
  end

  always_comb begin
    for (int i = 0; i < RowBits; i++) c0mask[i] = CntBits'(i) >= c0;
  end

  always_comb begin
    if (colmode) mask = RowBits'(1) << d_q;
    else mask = nmask & (chk_first ? c0mask : '1);
  end
  assign masked = pres_eff & mask;

  always_comb begin
    first_idx = '0;
    for (int i = RowBits - 1; i >= 0; i--) begin
      if (masked[i]) first_idx = IdxBits'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      if (f_q == FN_NEXT_IN && !incl_q) r <= {1'b0, s_q} + CntBits'(1);
      else if (f_q == FN_IN_DEGREE || f_q == FN_COUNT_ALL) r <= '0;
      else r <= {1'b0, s_q};
      if (f_q == FN_NEXT_OUT || f_q == FN_OUT_DEGREE) rend <= {1'b0, s_q} + CntBits'(1);
      else rend <= n;
      if (f_q == FN_NEXT_EDGE || f_q == FN_NEXT_OUT) begin
        c0 <= incl_q ? {1'b0, d_q} : {1'b0, d_q} + CntBits'(1);
      end else begin
        c0 <= '0;
      end
      colmode <= (f_q == FN_NEXT_IN) || (f_q == FN_IN_DEGREE);
      for (int i = 0; i < RowBits; i++) nmask[i] <= CntBits'(i) < n;
      fst   <= 1'b1;
      chk_v <= 1'b0;
      cnt   <= '0;
    end else if (cmd.scan) begin
      if (issue) begin
        r   <= r + CntBits'(1);
        fst <= 1'b0;
      end
      chk_v     <= issue;
      chk_row   <= r[IdxBits-1:0];
      chk_first <= fst;
      if (chk_v) begin
        cnt <= cnt + CountBits'(popcount(masked));
        if (masked != '0) begin
          fr <= chk_row;
          fc <= first_idx;
        end
      end
    end
  end

  always_comb begin
    sts.func      = f_q;
    sts.bad       = (f_q <= FN_NEXT_OUT && !(sok && dok)) ||
                    (f_q == FN_IN_DEGREE && !dok) || (f_q == FN_OUT_DEGREE && !sok);
    sts.mirror    = !directed && (s_q != d_q);
    sts.present   = pres_eff[d_q];
    sts.hit       = cmd.scan && chk_v && (masked != '0) && (f_q <= FN_NEXT_OUT);
    sts.scan_done = cmd.scan && !chk_v && !(r < rend);
    sts.out_free  = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (cmd.load) rsp_valid <= 1'b1;
    else if (!rsp_stall) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status       <= ST_OK;
      found_src    <= s_q;
      found_dst    <= d_q;
      edge_present <= 1'b0;
      weight_out   <= '0;
      count_value  <= '0;
      unique case (cmd.kind)
        RK_ZERO: begin
          found_src <= '0;
          found_dst <= '0;
        end
        RK_NOVERT: status <= ST_NOVERT;
        RK_CONN: begin
          edge_present <= 1'b1;
          weight_out   <= W_ONE;
        end
        RK_DISC: weight_out <= ever_q ? w_rdata : '0;
        RK_QRY: begin
          if (present_q) begin
            edge_present <= 1'b1;
            weight_out   <= (f_q == FN_SET_WEIGHT) ? w_q : w_rdata;
          end else begin
            status <= ST_NOEDGE;
          end
        end
        RK_END:   status <= ST_END;
        RK_COUNT: count_value <= cnt;
        RK_FOUND: begin
          found_src    <= fr;
          found_dst    <= fc;
          edge_present <= 1'b1;
          weight_out   <= w_rdata;
        end
        default: ;
      endcase
    end
  end

endmodule
